### rtl/ptw_pkg.sv
// Shared types and constants for the two-level page table engine.
`timescale 1ns / 1ps
package ptw_pkg;
   localparam int unsigned DIR_W      = 10;
   localparam int unsigned PTI_W      = 10;
   localparam int unsigned VPN_W      = 20;
   localparam int unsigned CNT_W      = 21;
   localparam int unsigned KDS_W      = 11;
   localparam int unsigned TE_W       = 23;
   localparam int unsigned ENTRIES_PER_TABLE = 1024;
   localparam logic [KDS_W-1:0] KDS_RESET = 11'd768;

   localparam logic [1:0] MODE_TRANSLATE = 2'd0;
   localparam logic [1:0] MODE_MAP       = 2'd1;
   localparam logic [1:0] MODE_UNMAP     = 2'd2;

   localparam logic [1:0] FLUSH_NONE = 2'd0;
   localparam logic [1:0] FLUSH_PAGE = 2'd1;
   localparam logic [1:0] FLUSH_ALL  = 2'd2;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NO_SLOT = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] vaddr;
      logic [31:0] phys_addr;
      logic [20:0] npages;
      logic [2:0]  flags;
   } req_word_type;

   typedef struct packed {
      logic        status;
      logic        found;
      logic [31:0] result_addr;
      logic [1:0]  flush_kind;
      logic [31:0] flush_addr;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_TR_DIR, ST_TR_TAB, ST_CH_RD, ST_CH_DEC,
      ST_ALLOC, ST_WALK
   } state_type;
endpackage

### rtl/ptw_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ptw_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/two_level_page_table_engine.sv
// Top level of the two-level page table engine.
`timescale 1ns / 1ps
// Usage: a command word on req_data is taken at a clock edge where start is
// high and busy is low. Mode translate walks the directory and then one page
// table; map and unmap walk a run of pages one entry per cycle inside a table.
// Every command produces exactly one response word on rsp_data, shown for a
// single cycle with rsp_valid high; the receiver cannot stall it.
// Sequence: translate reads the directory, then the page table, and then
// registers the response (two dependent reads of the synchronous memories).
// Map and unmap read and decide on the directory entry of each table touched,
// then write one entry per page of a present table; a map that must allocate
// a table first clears its 1024 entries. The next command may be accepted in
// the cycle the response is shown. Unused modes and zero page counts are
// answered straight from idle, with no walk. Reset: a sweep clears all 1024
// directory entries with busy high; the free-slot bitmap and kernel_dir_start
// reset at once. The user must write kernel_dir_start via csr_we/csr_wdata
// only while the block is idle; the block does not enforce this. Tables at
// or above that directory index are never freed.
module two_level_page_table_engine #(
   parameter int unsigned TABLE_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ptw_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   output ptw_pkg::rsp_word_type rsp_data,
   input  logic                  csr_we,
   input  logic [10:0]           csr_wdata
);
   import ptw_pkg::*;

   localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int unsigned DE_W   = SLOT_W + 3;
   localparam int unsigned TAB_D  = TABLE_SLOTS * ENTRIES_PER_TABLE;
   localparam int unsigned TA_W   = $clog2(TAB_D);

   state_type state_ff, state_in;
   req_word_type req_ff, req_in;
   rsp_word_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [KDS_W-1:0] kds_ff;
   logic [TABLE_SLOTS-1:0] free_ff, free_in;
   logic [CNT_W-1:0] vpn_ff, vpn_in, n_ff, n_in;
   logic [VPN_W-1:0] ppn_ff, ppn_in;
   logic [PTI_W:0] left_ff, left_in;
   logic [PTI_W-1:0] sweep_ff, sweep_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // Directory memory: {slot, user, writable, present}.
   logic dir_we;
   logic [DIR_W-1:0] dir_waddr, dir_raddr;
   logic [DE_W-1:0] dir_wdata, dir_rdata;
   // Table memory: {frame, flags}.
   logic tab_we;
   logic [TA_W-1:0] tab_waddr, tab_raddr;
   logic [TE_W-1:0] tab_wdata, tab_rdata;

   ptw_ram #(.WIDTH(DE_W), .DEPTH(1024)) u_dir (
      .clock(clock), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
      .raddr(dir_raddr), .rdata(dir_rdata)
   );

   ptw_ram #(.WIDTH(TE_W), .DEPTH(TAB_D)) u_tab (
      .clock(clock), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
      .raddr(tab_raddr), .rdata(tab_rdata)
   );

   // Lowest free slot.
   logic [SLOT_W-1:0] free_idx;
   logic              free_any;
   always_comb begin
      free_idx = '0;
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
      free_any = |free_ff;
   end

   logic [CNT_W-1:0] room_top, n_clamp;
   logic [PTI_W:0]   room, chunk;
   logic [DIR_W-1:0] pdi;
   logic [PTI_W-1:0] pti;
   logic [SLOT_W-1:0] dir_slot;
   rsp_word_type done_rsp;

   always_comb begin
      room_top = CNT_W'(1 << VPN_W) - {1'b0, req_data.vaddr[31:12]};
      n_clamp  = (req_data.npages > room_top) ? room_top : req_data.npages;
      pdi      = vpn_ff[19:10];
      pti      = vpn_ff[9:0];
      room     = (PTI_W+1)'(ENTRIES_PER_TABLE) - {1'b0, pti};
      chunk    = (n_ff < CNT_W'(room)) ? n_ff[PTI_W:0] : room;
      dir_slot = dir_rdata[DE_W-1:3];
      // Response for a completed map or unmap.
      done_rsp = '0;
      if (req_ff.npages == CNT_W'(1)) begin
         done_rsp.flush_kind = FLUSH_PAGE;
         done_rsp.flush_addr = {req_ff.vaddr[31:12], 12'h000};
      end else begin
         done_rsp.flush_kind = FLUSH_ALL;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      free_in = free_ff;
      vpn_in = vpn_ff;
      n_in = n_ff;
      ppn_in = ppn_ff;
      left_in = left_ff;
      sweep_in = sweep_ff;
      slot_in = slot_ff;
      dir_we = 1'b0;
      dir_waddr = pdi;
      dir_wdata = '0;
      dir_raddr = pdi;
      tab_we = 1'b0;
      tab_waddr = TA_W'({slot_ff, pti});
      tab_wdata = '0;
      tab_raddr = TA_W'({dir_slot, req_ff.vaddr[21:12]});
      case (state_ff)
         ST_CLEAR: begin
            dir_we = 1'b1;
            dir_waddr = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            dir_raddr = req_data.vaddr[31:22];
            if (start) begin
               req_in = req_data;
               vpn_in = {1'b0, req_data.vaddr[31:12]};
               ppn_in = req_data.phys_addr[31:12];
               n_in = n_clamp;
               if (req_data.mode == MODE_TRANSLATE) begin
                  state_in = ST_TR_DIR;
               end else if ((req_data.mode == MODE_MAP || req_data.mode == MODE_UNMAP)
                            && req_data.npages != '0) begin
                  state_in = ST_CH_RD;
               end else begin
                  rsp_in = '0;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_TR_DIR: begin
            if (dir_rdata[0]) begin
               state_in = ST_TR_TAB;
            end else begin
               rsp_in = '0;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_TR_TAB: begin
            rsp_in = '0;
            if (tab_rdata[0]) begin
               rsp_in.found = 1'b1;
               rsp_in.result_addr = {tab_rdata[TE_W-1:3], req_ff.vaddr[11:0]};
            end
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CH_RD: begin
            state_in = ST_CH_DEC;
         end
         ST_CH_DEC: begin
            left_in = chunk;
            slot_in = dir_slot;
            if (req_ff.mode == MODE_MAP) begin
               if (dir_rdata[0]) begin
                  state_in = ST_WALK;
               end else if (free_any) begin
                  free_in[free_idx] = 1'b0;
                  slot_in = free_idx;
                  dir_we = 1'b1;
                  dir_wdata = {free_idx, req_ff.flags[2], 2'b11};
                  sweep_in = '0;
                  state_in = ST_ALLOC;
               end else begin
                  rsp_in = '0;
                  rsp_in.status = STATUS_NO_SLOT;
                  rsp_valid_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (dir_rdata[0]) begin
               state_in = ST_WALK;
               if (pti == '0 && chunk == (PTI_W+1)'(ENTRIES_PER_TABLE)
                   && {1'b0, pdi} < kds_ff) begin
                  // Whole user table emptied: release it now; the walk still
                  // clears its entries.
                  free_in[dir_slot] = 1'b1;
                  dir_we = 1'b1;
               end
            end else begin
               vpn_in = vpn_ff + CNT_W'(chunk);
               n_in = n_ff - CNT_W'(chunk);
               if (n_ff == CNT_W'(chunk)) begin
                  rsp_in = done_rsp;
                  rsp_valid_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_CH_RD;
               end
            end
         end
         ST_ALLOC: begin
            tab_we = 1'b1;
            tab_waddr = TA_W'({slot_ff, sweep_ff});
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // A non-present entry is always zero, so unmap writes zero blindly.
            tab_we = 1'b1;
            if (req_ff.mode == MODE_MAP) begin
               tab_wdata = {ppn_ff, req_ff.flags | 3'b001};
            end
            ppn_in = ppn_ff + 1'b1;
            vpn_in = vpn_ff + 1'b1;
            n_in = n_ff - 1'b1;
            left_in = left_ff - 1'b1;
            if (left_ff == (PTI_W+1)'(1)) begin
               if (n_ff == CNT_W'(1)) begin
                  rsp_in = done_rsp;
                  rsp_valid_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_CH_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         free_ff <= '1;
         sweep_ff <= '0;
         kds_ff <= KDS_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_ff <= free_in;
         sweep_ff <= sweep_in;
         if (csr_we) begin
            kds_ff <= csr_wdata;
         end
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      vpn_ff <= vpn_in;
      n_ff <= n_in;
      ppn_ff <= ppn_in;
      left_ff <= left_in;
      slot_ff <= slot_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

### rtl/ptw_checker.sv
// Port-level checker for the page table engine, bound to the top level.
`timescale 1ns / 1ps
module ptw_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input ptw_pkg::rsp_word_type rsp_data
);
   import ptw_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");
   // A word either starts a walk or is answered in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted word neither raised busy nor answered");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.result_addr == '0)
      else $error("address reported without a hit");
   a_found_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.status == STATUS_OK
                                      && rsp_data.flush_kind == FLUSH_NONE)
      else $error("translate word carries status or flush");
endmodule

bind two_level_page_table_engine ptw_checker u_ptw_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

### tb/two_level_page_table_engine_tb.sv
// Self-checking testbench for the two-level page table engine.
`timescale 1ns / 1ps
module two_level_page_table_engine_tb;
   import ptw_pkg::*;

   // Table pool size used both for the block and for the predictor below.
   localparam int unsigned SLOTS = 16;
   localparam int unsigned TOTAL_PAGES = 32'h10_0000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // Cycles with no accepted word or response before the run is abandoned.
   // The slowest single command here maps some fifteen thousand pages and
   // clears fifteen tables, still well under this limit.
   localparam int unsigned IDLE_LIMIT = 200000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_data = '0;
   logic         rsp_valid;
   rsp_word_type rsp_data;
   logic         csr_we = 1'b0;
   logic [10:0]  csr_wdata = '0;

   // Shadow copy of the engine state, kept in step with every accepted word.
   logic [2:0]        dir_flags [1024];
   int unsigned       dir_slot  [1024];
   logic [TE_W-1:0]   shadow_pte [SLOTS*ENTRIES_PER_TABLE];
   logic [SLOTS-1:0]  slot_free;
   logic [KDS_W-1:0]  kernel_start;

   rsp_word_type pending_rsp [$];
   int unsigned  error_count = 0;
   int unsigned  words_sent = 0;
   int unsigned  words_checked = 0;
   int unsigned  map_failures = 0;
   int unsigned  idle_cycles = 0;

   always #1 clock = ~clock;

   two_level_page_table_engine #(
      .TABLE_SLOTS(SLOTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   // Computes the response the engine owes for one command word and applies
   // the command to the shadow state. Map and unmap advance one table at a
   // time, exactly as the hardware walks them.
   function automatic rsp_word_type walk_tables(req_word_type w);
      rsp_word_type r;
      int unsigned  vpn, ppn, n, pdi, pti, chunk, base, s, k;
      logic [TE_W-1:0] e;
      r = '0;
      if (w.mode == MODE_TRANSLATE) begin
         pdi = w.vaddr[31:22];
         if (dir_flags[pdi][0]) begin
            e = shadow_pte[dir_slot[pdi]*ENTRIES_PER_TABLE + w.vaddr[21:12]];
            if (e[0]) begin
               r.found = 1'b1;
               r.result_addr = {e[22:3], w.vaddr[11:0]};
            end
         end
         return r;
      end
      if (w.mode == MODE_UNUSED || w.npages == 0) return r;

      vpn = w.vaddr[31:12];
      ppn = w.phys_addr[31:12];
      n = w.npages;
      // A run that passes the top of the address space stops at the last page.
      if (n > TOTAL_PAGES - vpn) n = TOTAL_PAGES - vpn;

      while (n > 0) begin
         pdi = vpn >> 10;
         pti = vpn & 32'h3FF;
         chunk = ENTRIES_PER_TABLE - pti;
         if (chunk > n) chunk = n;
         if (w.mode == MODE_MAP) begin
            if (!dir_flags[pdi][0]) begin
               s = SLOTS;
               for (k = 0; k < SLOTS; k++)
                  if (slot_free[k] && s == SLOTS) s = k;
               if (s == SLOTS) begin
                  // Pool is dry: earlier tables of this run stay mapped.
                  r.status = STATUS_NO_SLOT;
                  return r;
               end
               slot_free[s] = 1'b0;
               for (k = 0; k < ENTRIES_PER_TABLE; k++)
                  shadow_pte[s*ENTRIES_PER_TABLE + k] = '0;
               dir_slot[pdi] = s;
               dir_flags[pdi] = {w.flags[2], 2'b11};
            end
            base = dir_slot[pdi] * ENTRIES_PER_TABLE;
            for (k = 0; k < chunk; k++)
               shadow_pte[base + pti + k] = {20'(ppn + k), w.flags | 3'b001};
            ppn = (ppn + chunk) & 32'hF_FFFF;
         end else if (dir_flags[pdi][0]) begin
            base = dir_slot[pdi] * ENTRIES_PER_TABLE;
            for (k = 0; k < chunk; k++)
               if (shadow_pte[base + pti + k][0]) shadow_pte[base + pti + k] = '0;
            // Only a fully covered table below the kernel boundary is released.
            if (pti == 0 && chunk == ENTRIES_PER_TABLE && pdi < kernel_start) begin
               slot_free[dir_slot[pdi]] = 1'b1;
               dir_flags[pdi] = '0;
               dir_slot[pdi] = 0;
            end
         end
         vpn += chunk;
         n -= chunk;
      end

      if (w.npages == 1) begin
         r.flush_kind = FLUSH_PAGE;
         r.flush_addr = {w.vaddr[31:12], 12'h000};
      end else begin
         r.flush_kind = FLUSH_ALL;
      end
      return r;
   endfunction

   // Every response word is checked against the oldest outstanding prediction.
   function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         error_count++;
         $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            error_count++;
            $display("%0t: response word with nothing outstanding, actual %h", $time, rsp_data);
         end else begin
            exp_w = pending_rsp.pop_front();
            words_checked++;
            compare_field("status", 32'(exp_w.status), 32'(rsp_data.status));
            compare_field("found", 32'(exp_w.found), 32'(rsp_data.found));
            compare_field("result_addr", exp_w.result_addr, rsp_data.result_addr);
            compare_field("flush_kind", 32'(exp_w.flush_kind), 32'(rsp_data.flush_kind));
            compare_field("flush_addr", exp_w.flush_addr, rsp_data.flush_addr);
         end
      end
   end

   // Watchdog: any accepted command or response word restarts the count.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired with %0d words outstanding", $time,
                  pending_rsp.size());
         $display("two_level_page_table_engine_tb failed");
         $finish;
      end
   end

   // Sends one command word after an idle gap of the given number of cycles.
   // With no gap, start stays high straight into the next word.
   task automatic send_word(req_word_type w, int unsigned gap);
      rsp_word_type exp_w;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      exp_w = walk_tables(w);
      if (w.mode == MODE_MAP && exp_w.status == STATUS_NO_SLOT) map_failures++;
      pending_rsp.push_back(exp_w);
      words_sent++;
   endtask

   task automatic send_cmd(logic [1:0] mode, logic [31:0] va, logic [31:0] pa,
                           logic [20:0] cnt, logic [2:0] flags);
      req_word_type w;
      w.mode = mode;
      w.vaddr = va;
      w.phys_addr = pa;
      w.npages = cnt;
      w.flags = flags;
      send_word(w, 0);
   endtask

   // Drops start and waits until every outstanding response has come back.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_kernel_start(logic [10:0] value);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      kernel_start = value;
   endtask

   // Translate with nothing mapped, then single pages, frame wrap, offsets,
   // zero counts and the unused mode.
   task automatic test_basic_map();
      send_cmd(MODE_TRANSLATE, 32'h0000_0000, 32'h0, 21'd0, 3'd0);
      send_cmd(MODE_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 21'h1F_FFFF, 3'd7);
      send_cmd(MODE_MAP, 32'h0040_0000, 32'hFFFF_F123, 21'd1, 3'd0);
      send_cmd(MODE_TRANSLATE, 32'h0040_0ABC, 32'h0, 21'd0, 3'd0);
      send_cmd(MODE_MAP, 32'h0050_0000, 32'h1234_5000, 21'd0, 3'd7);
      send_cmd(MODE_UNMAP, 32'h0040_0000, 32'h0, 21'd0, 3'd0);
      send_cmd(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 21'h1F_FFFF, 3'd7);
      // Unaligned map whose physical frames wrap past the top.
      send_cmd(MODE_MAP, 32'h0040_1ABC, 32'hFFFF_E000, 21'd3, 3'd7);
      send_cmd(MODE_TRANSLATE, 32'h0040_3FFF, 32'h0, 21'd0, 3'd0);
   endtask

   // Runs past the top of the address space are clamped at the last page.
   task automatic test_clamp_and_kernel_table();
      send_cmd(MODE_MAP, 32'hFFFF_F000, 32'hABCD_E000, 21'h1F_FFFF, 3'd6);
      send_cmd(MODE_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 21'd0, 3'd0);
      send_cmd(MODE_MAP, 32'hFFFF_E000, 32'h0000_0000, 21'h10_0000, 3'd2);
      // Whole kernel table unmapped: entries go, the table stays.
      send_cmd(MODE_UNMAP, 32'hFFC0_0000, 32'h0, 21'd1024, 3'd0);
      send_cmd(MODE_TRANSLATE, 32'hFFFF_E000, 32'h0, 21'd0, 3'd0);
      // Whole user table unmapped: the slot returns to the pool.
      send_cmd(MODE_UNMAP, 32'h0040_0FFF, 32'h0, 21'd1024, 3'd0);
      send_cmd(MODE_UNMAP, 32'h0140_0000, 32'h0, 21'd2, 3'd0);
   endtask

   // One run that needs more tables than the pool holds, then release them.
   task automatic test_pool_exhaustion();
      send_cmd(MODE_MAP, 32'h1900_0000, 32'h8000_0000, 21'(17*1024), 3'd5);
      send_cmd(MODE_TRANSLATE, 32'h1CC0_0010, 32'h0, 21'd0, 3'd0);
      send_cmd(MODE_TRANSLATE, 32'h1900_0010, 32'h0, 21'd0, 3'd0);
      send_cmd(MODE_UNMAP, 32'h1900_0000, 32'h0, 21'(16*1024), 3'd0);
      send_cmd(MODE_MAP, 32'h1900_0000, 32'h0000_1000, 21'd2, 3'd1);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Random commands aimed mostly at a few directory entries at the bottom,
   // on either side of the usual kernel boundary and at the top, so that maps,
   // hits, frees and pool exhaustion all come round again and again.
   task automatic test_random_traffic(int unsigned count, bit bursty);
      req_word_type w;
      int unsigned  i, roll, pdi, pti;
      int unsigned  hot_dirs [10] = '{0, 1, 2, 3, 766, 767, 768, 769, 1022, 1023};
      for (i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         w.mode = (roll < 35) ? MODE_TRANSLATE : (roll < 66) ? MODE_MAP :
                  (roll < 97) ? MODE_UNMAP : MODE_UNUSED;
         pdi = ($urandom_range(99) < 85) ? hot_dirs[$urandom_range(9)] : $urandom_range(1023);
         pti = ($urandom_range(99) < 20) ? 0 : $urandom_range(1023);
         w.vaddr = {pdi[9:0], pti[9:0], 12'($urandom)};
         w.phys_addr = $urandom;
         w.flags = 3'($urandom);
         roll = $urandom_range(99);
         if (roll < 5) begin
            w.npages = 21'd0;
         end else if (roll < 25) begin
            w.npages = 21'd1;
         end else if (roll < 80) begin
            w.npages = 21'($urandom_range(32, 2));
         end else if (roll < 88) begin
            w.npages = 21'($urandom_range(1024, 33));
         end else if (roll < 95) begin
            w.npages = 21'd1024;
            w.vaddr[21:12] = '0;
         end else begin
            // Huge counts only near the top, where the clamp keeps them short.
            w.npages = 21'($urandom);
            w.vaddr[31:20] = 12'hFFF;
         end
         send_word(w, bursty ? 0 : pick_gap());
      end
   endtask

   initial begin
      int unsigned k;
      for (k = 0; k < 1024; k++) begin
         dir_flags[k] = '0;
         dir_slot[k] = 0;
      end
      for (k = 0; k < SLOTS*ENTRIES_PER_TABLE; k++) shadow_pte[k] = '0;
      slot_free = '1;
      kernel_start = KDS_RESET;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_map();
      test_clamp_and_kernel_table();
      test_pool_exhaustion();

      // Kernel boundary above every index: every whole table can be freed.
      write_kernel_start(11'd1024);
      test_random_traffic(160, 1'b0);
      // Boundary at zero: nothing is ever freed, so the pool runs dry.
      write_kernel_start(11'd0);
      test_random_traffic(120, 1'b1);
      write_kernel_start(11'($urandom_range(1023, 1)));
      test_random_traffic(180, 1'b0);
      write_kernel_start(11'h7FF);
      test_random_traffic(60, 1'b0);
      write_kernel_start(KDS_RESET);
      test_random_traffic(130, 1'b0);

      drain();
      repeat (50) @(posedge clock);
      $display("Sent %0d command words and checked %0d responses under five kernel boundaries;",
               words_sent, words_checked);
      $display("%0d maps ran out of table slots, %0d mismatches seen.", map_failures,
               error_count);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("two_level_page_table_engine_tb passed");
      end else begin
         $display("two_level_page_table_engine_tb failed");
      end
      $finish;
   end
endmodule
